[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define KCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define KCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/kcd_pkg.sv]
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants of the keyed cache directory.
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int COORD_BITS_DEF  = 24;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int LEVEL_W  = 3;
    localparam int SIZE_W   = 32;
    localparam int BYTES_W  = 48;
    localparam int STAMP_W  = 32;
    localparam int MAXENT_W = 5;
    localparam int POLICY_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUT      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GET      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LFU  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd2;

    localparam logic [1:0] REG_POLICY      = 2'd0;
    localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
    localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_RST      = POL_LRU;
    localparam logic [MAXENT_W-1:0] MAX_ENTRIES_RST = 5'd16;
    localparam logic [BYTES_W-1:0]  MAX_BYTES_RST   = 48'd268435456;
    localparam logic [BYTES_W-1:0]  BYTES_MAX       = {BYTES_W{1'b1}};
    localparam logic [STAMP_W-1:0]  USE_MAX         = {STAMP_W{1'b1}};

    // per-cell update commands
    typedef struct packed {
        logic wr;
        logic drop;
        logic bump;
        logic clr;
    } cell_ctrl_t;

    // victim search token passed along the chain
    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] val;
    } best_tok_t;

endpackage

[rtl/keyed_cache_directory_replacement_top.sv]
// ----------------------------------------------------------------------------
// keyed_cache_directory_replacement_top
// Fully associative keyed directory with LRU / LFU / FIFO replacement.
// ----------------------------------------------------------------------------
// Order: get, remove, contains, clear and refused put pass S_EXEC, then the
//   registered answer beat. A put goes S_EXEC, S_CHECK, one S_SEARCH wait per
//   eviction (each victim search walks the cell chain one slot a cycle), S_INSERT.
// Throughput: one item at a time; busy is high until the answer beat is out.
// Results cannot be stalled; each beat is shown for one cycle on result_valid.
// Reset (rst_n low, async): directory empty, totals and stamp zero, registers
//   at their defaults.
module keyed_cache_directory_replacement_top #(
    parameter int CAPACITY    = kcd_pkg::CAPACITY_DEF,
    parameter int COORD_BITS  = kcd_pkg::COORD_BITS_DEF,
    parameter int HANDLE_BITS = kcd_pkg::HANDLE_BITS_DEF,
    localparam int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [4:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready,
    // command
    input  logic                                 start,
    output logic                                 busy,
    input  logic [kcd_pkg::ACTION_W-1:0]         action,
    input  logic signed [COORD_BITS-1:0]         coord_x,
    input  logic signed [COORD_BITS-1:0]         coord_z,
    input  logic [kcd_pkg::LEVEL_W-1:0]          level,
    input  logic [HANDLE_BITS-1:0]               entry_handle,
    input  logic [kcd_pkg::SIZE_W-1:0]           entry_size,
    // results
    output logic                                 result_valid,
    output logic                                 kind,
    output logic                                 found,
    output logic [HANDLE_BITS-1:0]               handle_out,
    output logic signed [COORD_BITS-1:0]         key_x_out,
    output logic signed [COORD_BITS-1:0]         key_z_out,
    output logic [kcd_pkg::LEVEL_W-1:0]          key_level_out,
    output logic [kcd_pkg::BYTES_W-1:0]          bytes_in_use,
    output logic [CNT_BITS-1:0]                  entries_in_use,
    output logic                                 last
);

    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int LW       = (CNT_BITS > kcd_pkg::MAXENT_W) ? CNT_BITS : kcd_pkg::MAXENT_W;
    localparam int BW       = kcd_pkg::BYTES_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_SEARCH,
        S_INSERT
    } state_t;

    state_t                          state_reg, state_next;

    // configuration registers
    logic [kcd_pkg::POLICY_W-1:0]    policy_reg;
    logic [kcd_pkg::MAXENT_W-1:0]    max_ent_reg;
    logic [BW-1:0]                   max_bytes_reg;

    // latched request
    logic [kcd_pkg::ACTION_W-1:0]    act_reg;
    logic [COORD_BITS-1:0]           rx_reg, rz_reg;
    logic [kcd_pkg::LEVEL_W-1:0]     rlvl_reg;
    logic [HANDLE_BITS-1:0]          rhandle_reg;
    logic [kcd_pkg::SIZE_W-1:0]      rsize_reg;

    logic [kcd_pkg::STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [BW-1:0]                   bytes_reg, bytes_next;
    logic [CNT_BITS-1:0]             count_reg, count_next;
    logic [CNT_BITS-1:0]             wait_reg, wait_next;

    // result beat
    logic                            rv_reg, rv_next;
    logic                            kind_reg, kind_next;
    logic                            found_reg, found_next;
    logic                            last_reg, last_next;
    logic [HANDLE_BITS-1:0]          rh_reg, rh_next;
    logic [COORD_BITS-1:0]           ox_reg, ox_next;
    logic [COORD_BITS-1:0]           oz_reg, oz_next;
    logic [kcd_pkg::LEVEL_W-1:0]     ol_reg, ol_next;

    // slot side
    logic                            drop_en, wr_en, bump_en, clr_en;
    logic [IDX_BITS-1:0]             drop_idx, wr_idx, bump_idx;
    kcd_pkg::cell_ctrl_t             cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0]             cell_valid, cell_hit;
    logic [HANDLE_BITS-1:0]          cell_handle [CAPACITY];
    logic [COORD_BITS-1:0]           cell_x [CAPACITY];
    logic [COORD_BITS-1:0]           cell_z [CAPACITY];
    logic [kcd_pkg::LEVEL_W-1:0]     cell_lvl [CAPACITY];
    logic [kcd_pkg::SIZE_W-1:0]      cell_size [CAPACITY];
    kcd_pkg::best_tok_t              tok [CAPACITY+1];
    logic [IDX_BITS-1:0]             tok_idx [CAPACITY+1];

    logic                            hit_any, free_any;
    logic [IDX_BITS-1:0]             hit_idx, free_idx;
    logic [LW-1:0]                   limit;
    logic                            need_evict;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // ------------------------------------------------------------------
    // Cell chain. The search token enters cell 0 empty and ripples one
    // cell a cycle; the tail is the victim once the chain has settled.
    // ------------------------------------------------------------------
    assign tok[0]     = '0;
    assign tok_idx[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        assign cell_ctrl[g] = '{
            wr:   wr_en   && (wr_idx   == IDX_BITS'(g)),
            drop: drop_en && (drop_idx == IDX_BITS'(g)),
            bump: bump_en && (bump_idx == IDX_BITS'(g)),
            clr:  clr_en
        };

        kcd_cell #(
            .COORD_BITS  (COORD_BITS),
            .HANDLE_BITS (HANDLE_BITS),
            .IDX_BITS    (IDX_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl[g]),
            .my_idx       (IDX_BITS'(g)),
            .req_x        (rx_reg),
            .req_z        (rz_reg),
            .req_level    (rlvl_reg),
            .req_handle   (rhandle_reg),
            .req_size     (rsize_reg),
            .stamp_now    (stamp_reg),
            .stamp_new    (stamp_reg + kcd_pkg::STAMP_W'(1)),
            .policy       (policy_reg),
            .best_in      (tok[g]),
            .best_idx_in  (tok_idx[g]),
            .best_out     (tok[g+1]),
            .best_idx_out (tok_idx[g+1]),
            .valid        (cell_valid[g]),
            .hit          (cell_hit[g]),
            .handle       (cell_handle[g]),
            .key_x        (cell_x[g]),
            .key_z        (cell_z[g]),
            .key_level    (cell_lvl[g]),
            .size         (cell_size[g])
        );
    end

    // lowest hit and lowest free slot
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_hit[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
            if (!cell_valid[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
    end

    // entry limit clamped to 1..CAPACITY
    always_comb
    begin
        if (max_ent_reg == '0)
            limit = LW'(1);
        else if (LW'(max_ent_reg) > LW'(CAPACITY))
            limit = LW'(CAPACITY);
        else
            limit = LW'(max_ent_reg);
    end

    assign need_evict = (count_reg != '0)
        && ((LW'(count_reg) >= limit)
            || (({1'b0, bytes_reg} + (BW+1)'(rsize_reg)) > {1'b0, max_bytes_reg}));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        stamp_next = stamp_reg;
        bytes_next = bytes_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        rv_next    = 1'b0;
        kind_next  = 1'b0;
        found_next = 1'b0;
        last_next  = 1'b1;
        rh_next    = '0;
        ox_next    = rx_reg;
        oz_next    = rz_reg;
        ol_next    = rlvl_reg;
        drop_en    = 1'b0;
        drop_idx   = hit_idx;
        wr_en      = 1'b0;
        wr_idx     = free_idx;
        bump_en    = 1'b0;
        bump_idx   = hit_idx;
        clr_en     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                rv_next    = 1'b1;
                case (act_reg)
                    kcd_pkg::ACT_PUT:
                    begin
                        if (rhandle_reg != '0)
                        begin
                            rv_next    = 1'b0;
                            state_next = S_CHECK;
                            if (hit_any)
                            begin
                                // re-put: old entry leaves silently
                                drop_en    = 1'b1;
                                bytes_next = (bytes_reg >= BW'(cell_size[hit_idx]))
                                             ? bytes_reg - BW'(cell_size[hit_idx]) : '0;
                                count_next = count_reg - CNT_BITS'(1);
                            end
                        end
                    end
                    kcd_pkg::ACT_GET:
                    begin
                        if (hit_any)
                        begin
                            bump_en    = 1'b1;
                            stamp_next = stamp_reg + kcd_pkg::STAMP_W'(1);
                            found_next = 1'b1;
                            rh_next    = cell_handle[hit_idx];
                        end
                    end
                    kcd_pkg::ACT_REMOVE:
                    begin
                        if (hit_any)
                        begin
                            drop_en    = 1'b1;
                            bytes_next = (bytes_reg >= BW'(cell_size[hit_idx]))
                                         ? bytes_reg - BW'(cell_size[hit_idx]) : '0;
                            count_next = count_reg - CNT_BITS'(1);
                            found_next = 1'b1;
                        end
                    end
                    kcd_pkg::ACT_CONTAINS:
                    begin
                        found_next = hit_any;
                        rh_next    = hit_any ? cell_handle[hit_idx] : '0;
                    end
                    kcd_pkg::ACT_CLEAR:
                    begin
                        clr_en     = 1'b1;
                        bytes_next = '0;
                        count_next = '0;
                        found_next = 1'b1;
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (need_evict)
                begin
                    state_next = S_SEARCH;
                    wait_next  = CNT_BITS'(CAPACITY);
                end
                else
                    state_next = S_INSERT;
            end
            S_SEARCH:
            begin
                if (wait_reg != '0)
                    wait_next = wait_reg - CNT_BITS'(1);
                else if (tok[CAPACITY].found)
                begin
                    drop_en    = 1'b1;
                    drop_idx   = tok_idx[CAPACITY];
                    bytes_next = (bytes_reg >= BW'(cell_size[tok_idx[CAPACITY]]))
                                 ? bytes_reg - BW'(cell_size[tok_idx[CAPACITY]]) : '0;
                    count_next = count_reg - CNT_BITS'(1);
                    rv_next    = 1'b1;
                    kind_next  = 1'b1;
                    found_next = 1'b1;
                    last_next  = 1'b0;
                    rh_next    = cell_handle[tok_idx[CAPACITY]];
                    ox_next    = cell_x[tok_idx[CAPACITY]];
                    oz_next    = cell_z[tok_idx[CAPACITY]];
                    ol_next    = cell_lvl[tok_idx[CAPACITY]];
                    state_next = S_CHECK;
                end
                else
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                state_next = S_IDLE;
                rv_next    = 1'b1;
                if (free_any)
                begin
                    wr_en      = 1'b1;
                    stamp_next = stamp_reg + kcd_pkg::STAMP_W'(1);
                    bytes_next = ((BW+1)'(bytes_reg) + (BW+1)'(rsize_reg) > (BW+1)'(kcd_pkg::BYTES_MAX))
                                 ? kcd_pkg::BYTES_MAX : bytes_reg + BW'(rsize_reg);
                    count_next = count_reg + CNT_BITS'(1);
                    found_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= kcd_pkg::POLICY_RST;
            max_ent_reg   <= kcd_pkg::MAX_ENTRIES_RST;
            max_bytes_reg <= kcd_pkg::MAX_BYTES_RST;
            stamp_reg     <= '0;
            bytes_reg     <= '0;
            count_reg     <= '0;
            wait_reg      <= '0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            bytes_reg <= bytes_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            rv_reg    <= rv_next;
            if (cfg_wr)
            begin
                case (paddr[4:3])
                    kcd_pkg::REG_POLICY:      policy_reg    <= pwdata[kcd_pkg::POLICY_W-1:0];
                    kcd_pkg::REG_MAX_ENTRIES: max_ent_reg   <= pwdata[kcd_pkg::MAXENT_W-1:0];
                    kcd_pkg::REG_MAX_BYTES:   max_bytes_reg <= pwdata[BW-1:0];
                    default:                  ;
                endcase
            end
        end
    end

    // request latch and result beat payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg     <= action;
            rx_reg      <= coord_x;
            rz_reg      <= coord_z;
            rlvl_reg    <= level;
            rhandle_reg <= entry_handle;
            rsize_reg   <= entry_size;
        end
        kind_reg  <= kind_next;
        found_reg <= found_next;
        last_reg  <= last_next;
        rh_reg    <= rh_next;
        ox_reg    <= ox_next;
        oz_reg    <= oz_next;
        ol_reg    <= ol_next;
    end

    always_comb
    begin
        case (paddr[4:3])
            kcd_pkg::REG_POLICY:      prdata = 64'(policy_reg);
            kcd_pkg::REG_MAX_ENTRIES: prdata = 64'(max_ent_reg);
            kcd_pkg::REG_MAX_BYTES:   prdata = 64'(max_bytes_reg);
            default:                  prdata = '0;
        endcase
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = rv_reg;
    assign kind           = kind_reg;
    assign found          = found_reg;
    assign handle_out     = rh_reg;
    assign key_x_out      = ox_reg;
    assign key_z_out      = oz_reg;
    assign key_level_out  = ol_reg;
    assign bytes_in_use   = bytes_reg;
    assign entries_in_use = count_reg;
    assign last           = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `KCD_ASSERT_IMP(a_mid_is_evict, result_valid && !last, kind && found)
    `KCD_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `KCD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_BITS'(CAPACITY))
    `KCD_ASSERT_IMP(a_count_matches, state_reg == S_IDLE,
                    count_reg == CNT_BITS'($countones(cell_valid)))

endmodule

[rtl/kcd_cell.sv]
// ----------------------------------------------------------------------------
// kcd_cell
// One directory slot: storage, key match and one stage of the victim search.
// ----------------------------------------------------------------------------
module kcd_cell #(
    parameter int COORD_BITS  = kcd_pkg::COORD_BITS_DEF,
    parameter int HANDLE_BITS = kcd_pkg::HANDLE_BITS_DEF,
    parameter int IDX_BITS    = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kcd_pkg::cell_ctrl_t           ctrl,
    input  logic [IDX_BITS-1:0]           my_idx,
    input  logic [COORD_BITS-1:0]         req_x,
    input  logic [COORD_BITS-1:0]         req_z,
    input  logic [kcd_pkg::LEVEL_W-1:0]   req_level,
    input  logic [HANDLE_BITS-1:0]        req_handle,
    input  logic [kcd_pkg::SIZE_W-1:0]    req_size,
    input  logic [kcd_pkg::STAMP_W-1:0]   stamp_now,
    input  logic [kcd_pkg::STAMP_W-1:0]   stamp_new,
    input  logic [kcd_pkg::POLICY_W-1:0]  policy,
    input  kcd_pkg::best_tok_t            best_in,
    input  logic [IDX_BITS-1:0]           best_idx_in,
    output kcd_pkg::best_tok_t            best_out,
    output logic [IDX_BITS-1:0]           best_idx_out,
    output logic                          valid,
    output logic                          hit,
    output logic [HANDLE_BITS-1:0]        handle,
    output logic [COORD_BITS-1:0]         key_x,
    output logic [COORD_BITS-1:0]         key_z,
    output logic [kcd_pkg::LEVEL_W-1:0]   key_level,
    output logic [kcd_pkg::SIZE_W-1:0]    size
);

    logic                         valid_reg;
    logic [COORD_BITS-1:0]        x_reg;
    logic [COORD_BITS-1:0]        z_reg;
    logic [kcd_pkg::LEVEL_W-1:0]  lvl_reg;
    logic [HANDLE_BITS-1:0]       handle_reg;
    logic [kcd_pkg::SIZE_W-1:0]   size_reg;
    logic [kcd_pkg::STAMP_W-1:0]  use_reg;
    logic [kcd_pkg::STAMP_W-1:0]  last_reg;
    logic [kcd_pkg::STAMP_W-1:0]  ins_reg;
    kcd_pkg::best_tok_t           best_reg;
    kcd_pkg::best_tok_t           best_next;
    logic [IDX_BITS-1:0]          best_idx_reg;
    logic [IDX_BITS-1:0]          best_idx_next;
    logic [kcd_pkg::STAMP_W-1:0]  metric;
    logic                         better;

    always_comb
    begin
        if (policy == kcd_pkg::POL_LFU)
        begin
            metric = use_reg;
            better = !best_in.found || (metric < best_in.val);
        end
        else
        begin
            metric = stamp_now - ((policy == kcd_pkg::POL_FIFO) ? ins_reg : last_reg);
            better = !best_in.found || (metric > best_in.val);
        end
        if (valid_reg && better)
        begin
            best_next     = '{found: 1'b1, val: metric};
            best_idx_next = my_idx;
        end
        else
        begin
            best_next     = best_in;
            best_idx_next = best_idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            if (ctrl.clr || ctrl.drop)
                valid_reg <= 1'b0;
            else if (ctrl.wr)
                valid_reg <= 1'b1;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            x_reg      <= req_x;
            z_reg      <= req_z;
            lvl_reg    <= req_level;
            handle_reg <= req_handle;
            size_reg   <= req_size;
            use_reg    <= kcd_pkg::STAMP_W'(1);
            last_reg   <= stamp_new;
            ins_reg    <= stamp_new;
        end
        else if (ctrl.bump)
        begin
            if (use_reg != kcd_pkg::USE_MAX)
                use_reg <= use_reg + kcd_pkg::STAMP_W'(1);
            last_reg <= stamp_new;
        end
    end

    assign hit          = valid_reg && (x_reg == req_x) && (z_reg == req_z)
                          && (lvl_reg == req_level);
    assign valid        = valid_reg;
    assign handle       = handle_reg;
    assign key_x        = x_reg;
    assign key_z        = z_reg;
    assign key_level    = lvl_reg;
    assign size         = size_reg;
    assign best_out     = best_reg;
    assign best_idx_out = best_idx_reg;

endmodule
